FILE: hdl/crle_pkg.sv
// Shared types, codes and fixed-point helpers for the Catmull-Rom loop evaluator.
// No dependencies; imported by the point bank, the axis lane and the top level.
`default_nettype none

package crle_pkg;

  localparam int CW = 40;
  localparam int PW = CW + 17;

  typedef logic signed [31:0]   coord_t;
  typedef logic signed [CW-1:0] acc_t;
  typedef logic signed [PW-1:0] prod_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic coef;
    logic mul1;
    logic add1;
    logic mul2;
    logic add2;
    logic mul3;
    logic add3;
  } lane_en_t;

  localparam logic OP_WRITE        = 1'b0;
  localparam logic OP_EVAL         = 1'b1;
  localparam logic REG_POINT_COUNT = 1'b0;

  localparam prod_t HALF16  = prod_t'(64'sd32768);
  localparam acc_t  SAT_HI  = acc_t'(64'sd2147483647);
  localparam acc_t  SAT_LO  = -acc_t'(64'sd2147483648);

  function automatic acc_t ext(input coord_t p);
    return acc_t'(p);
  endfunction

  function automatic acc_t rnd16(input prod_t p);
    prod_t q;
    q = p + HALF16;
    q = q >>> 16;
    return acc_t'(q[CW-1:0]);
  endfunction

  function automatic coord_t sat_r1(input acc_t h);
    acc_t r;
    r = (h + acc_t'(1)) >>> 1;
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return coord_t'(r[31:0]);
  endfunction

endpackage

`default_nettype wire

FILE: hdl/crle_point_bank.sv
// One copy of the control point table: one write port, one registered read port.
// Depends on crle_pkg for the point type.
`default_nettype none

module crle_point_bank #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire crle_pkg::point_t wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output crle_pkg::point_t      rdata
);
  import crle_pkg::*;

  point_t mem [DEPTH];
  point_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: hdl/crle_axis_lane.sv
// One axis of the evaluator: coefficients, Horner position and slope over seven stages.
// Depends on crle_pkg for types, stage enables and rounding helpers.
`default_nettype none

module crle_axis_lane (
  input  wire logic               clk,
  input  wire crle_pkg::lane_en_t en,
  input  wire crle_pkg::coord_t   p0,
  input  wire crle_pkg::coord_t   p1,
  input  wire crle_pkg::coord_t   p2,
  input  wire crle_pkg::coord_t   p3,
  input  wire logic [15:0]        t_in,
  output crle_pkg::coord_t        pos,
  output crle_pkg::coord_t        slope
);
  import crle_pkg::*;

  acc_t        c0_nxt, d0_nxt, c1_nxt, c2_nxt, c3_nxt;
  acc_t        cf_c0_r, cf_d0_r, cf_c1_r, cf_c2_r, cf_c3_r;
  logic [15:0] cf_t_r;

  prod_t       m1_ph_r, m1_pd_r;
  acc_t        m1_c1_r, m1_c2_r, m1_c3_r;
  logic [15:0] m1_t_r;

  acc_t        h1_nxt, e1_nxt;
  acc_t        a1_h_r, a1_e_r, a1_c2_r, a1_c3_r;
  logic [15:0] a1_t_r;

  prod_t       m2_ph_r, m2_pd_r;
  acc_t        m2_c2_r, m2_c3_r;
  logic [15:0] m2_t_r;

  acc_t        h2_nxt, e2_nxt;
  acc_t        a2_h_r, a2_e_r, a2_c3_r;
  logic [15:0] a2_t_r;

  prod_t       m3_ph_r;
  coord_t      m3_slope_r;
  acc_t        m3_c3_r;

  acc_t        h3_nxt;
  acc_t        a3_h_r;
  coord_t      a3_slope_r;

  logic signed [16:0] cf_ts, a1_ts, a2_ts;

  assign cf_ts = signed'({1'b0, cf_t_r});
  assign a1_ts = signed'({1'b0, a1_t_r});
  assign a2_ts = signed'({1'b0, a2_t_r});

  always_comb begin
    acc_t a0, a1, a2, a3;
    a0 = ext(p0);
    a1 = ext(p1);
    a2 = ext(p2);
    a3 = ext(p3);
    c0_nxt = a3 - a0 + (a1 <<< 1) + a1 - (a2 <<< 1) - a2;
    d0_nxt = c0_nxt + (c0_nxt <<< 1);
    c1_nxt = (a0 <<< 1) - (a1 <<< 2) - a1 + (a2 <<< 2) - a3;
    c2_nxt = a2 - a0;
    c3_nxt = a1 <<< 1;
  end

  assign h1_nxt = rnd16(m1_ph_r) + m1_c1_r;
  assign e1_nxt = rnd16(m1_pd_r) + (m1_c1_r <<< 1);
  assign h2_nxt = rnd16(m2_ph_r) + m2_c2_r;
  assign e2_nxt = rnd16(m2_pd_r) + m2_c2_r;
  assign h3_nxt = rnd16(m3_ph_r) + m3_c3_r;

  always_ff @(posedge clk) begin
    if (en.coef) begin
      cf_c0_r <= c0_nxt;
      cf_d0_r <= d0_nxt;
      cf_c1_r <= c1_nxt;
      cf_c2_r <= c2_nxt;
      cf_c3_r <= c3_nxt;
      cf_t_r  <= t_in;
    end
    if (en.mul1) begin
      m1_ph_r <= cf_c0_r * cf_ts;
      m1_pd_r <= cf_d0_r * cf_ts;
      m1_c1_r <= cf_c1_r;
      m1_c2_r <= cf_c2_r;
      m1_c3_r <= cf_c3_r;
      m1_t_r  <= cf_t_r;
    end
    if (en.add1) begin
      a1_h_r  <= h1_nxt;
      a1_e_r  <= e1_nxt;
      a1_c2_r <= m1_c2_r;
      a1_c3_r <= m1_c3_r;
      a1_t_r  <= m1_t_r;
    end
    if (en.mul2) begin
      m2_ph_r <= a1_h_r * a1_ts;
      m2_pd_r <= a1_e_r * a1_ts;
      m2_c2_r <= a1_c2_r;
      m2_c3_r <= a1_c3_r;
      m2_t_r  <= a1_t_r;
    end
    if (en.add2) begin
      a2_h_r  <= h2_nxt;
      a2_e_r  <= e2_nxt;
      a2_c3_r <= m2_c3_r;
      a2_t_r  <= m2_t_r;
    end
    if (en.mul3) begin
      m3_ph_r    <= a2_h_r * a2_ts;
      m3_slope_r <= sat_r1(a2_e_r);
      m3_c3_r    <= a2_c3_r;
    end
    if (en.add3) begin
      a3_h_r     <= h3_nxt;
      a3_slope_r <= m3_slope_r;
    end
  end

  assign pos   = sat_r1(a3_h_r);
  assign slope = a3_slope_r;

endmodule

`default_nettype wire

FILE: hdl/catmull_rom_loop_evaluator.sv
// Top level of the closed uniform Catmull-Rom loop evaluator: control, table and lanes.
// Depends on crle_pkg, crle_point_bank and crle_axis_lane.
`default_nettype none

// Takes one item per clock, writes and evaluations alike, with no gaps while the
// result side keeps up. An evaluation passes through these stages in order: one stage
// scales the time by the point count, one reads the table, seven run the three axis
// lanes (coefficients, then three multiply and round steps of Horner's rule with the
// slope alongside) and one merges the lanes into the output register. The table is
// held in four identical copies, one per neighbour, so all four points come out in
// the same read cycle. A write item updates the table when it passes the read
// stage and leaves no result; stages that hold no item are filled while a result
// waits, so the input stalls only once every stage is occupied. Table entries are
// undefined until written.
module catmull_rom_loop_evaluator #(
  parameter int MAX_POINTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,

  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_op,
  input  wire logic [5:0]       in_point_index,
  input  wire crle_pkg::coord_t in_coord_x,
  input  wire crle_pkg::coord_t in_coord_y,
  input  wire crle_pkg::coord_t in_coord_z,
  input  wire logic [15:0]      in_global_time,

  output logic                  out_valid,
  input  wire logic             out_stall,
  output crle_pkg::coord_t      out_pos_x,
  output crle_pkg::coord_t      out_pos_y,
  output crle_pkg::coord_t      out_pos_z,
  output crle_pkg::coord_t      out_slope_x,
  output crle_pkg::coord_t      out_slope_y,
  output crle_pkg::coord_t      out_slope_z,

  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [2:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import crle_pkg::*;

  localparam int AW    = $clog2(MAX_POINTS);
  localparam int IW    = (AW > 7) ? AW : 7;
  localparam int CAP   = (MAX_POINTS < 127) ? MAX_POINTS : 127;
  localparam logic [6:0] CAP_N = 7'(CAP);
  localparam int NST   = 10;

  logic [6:0]     point_count_r, point_count_nxt;
  logic [6:0]     n_eff;
  logic [22:0]    span;
  logic [IW-1:0]  widx;
  logic           w_in_range;

  logic [NST-1:0] valid_r, valid_nxt;
  logic [NST-1:0] en;

  logic           s1_op_r;
  logic           s1_wen_r;
  logic [AW-1:0]  s1_waddr_r;
  point_t         s1_point_r;
  logic [6:0]     s1_seg_r;
  logic [6:0]     s1_n_r;
  logic [15:0]    s1_t_r;
  logic [15:0]    s2_t_r;

  logic [IW-1:0]  seg_w, n_w, idx0, idx1, idx2, idx3;
  logic           mem_we;
  point_t         pt0, pt1, pt2, pt3;

  lane_en_t       lane_en;
  coord_t         pos_x, pos_y, pos_z, slope_x, slope_y, slope_z;
  coord_t         pos_x_r, pos_y_r, pos_z_r, slope_x_r, slope_y_r, slope_z_r;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_POINT_COUNT) ? 32'(point_count_r) : 32'd0;

  always_comb begin
    point_count_nxt = point_count_r;
    if (psel && penable && pwrite && pready && (paddr[2] == REG_POINT_COUNT)) begin
      point_count_nxt = pwdata[6:0];
    end
  end

  assign n_eff = (point_count_r == 7'd0) ? 7'd1 :
                 (point_count_r > CAP_N) ? CAP_N : point_count_r;
  assign span       = 23'(in_global_time) * 23'(n_eff);
  assign widx       = IW'(in_point_index);
  assign w_in_range = (32'(in_point_index) < 32'(MAX_POINTS));

  // advance a stage when it is empty or its item moves on
  always_comb begin
    en[NST-1] = !valid_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_comb begin
    valid_nxt = valid_r;
    if (en[0]) begin
      valid_nxt[0] = in_valid;
    end
    if (en[1]) begin
      valid_nxt[1] = valid_r[0] && (s1_op_r == OP_EVAL);
    end
    for (int k = 2; k < NST; k++) begin
      if (en[k]) begin
        valid_nxt[k] = valid_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= 7'd4;
      valid_r       <= '0;
    end else begin
      point_count_r <= point_count_nxt;
      valid_r       <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_op_r      <= in_op;
      s1_wen_r     <= w_in_range;
      s1_waddr_r   <= widx[AW-1:0];
      s1_point_r.x <= in_coord_x;
      s1_point_r.y <= in_coord_y;
      s1_point_r.z <= in_coord_z;
      s1_seg_r     <= span[22:16];
      s1_n_r       <= n_eff;
      s1_t_r       <= span[15:0];
    end
    if (en[1]) begin
      s2_t_r <= s1_t_r;
    end
  end

  // wrap the neighbour indices around the loop
  always_comb begin
    seg_w = IW'(s1_seg_r);
    n_w   = IW'(s1_n_r);
    idx1  = seg_w;
    idx0  = (seg_w == '0) ? (n_w - IW'(1)) : (seg_w - IW'(1));
    idx2  = ((seg_w + IW'(1)) == n_w) ? '0 : (seg_w + IW'(1));
    idx3  = ((idx2 + IW'(1)) == n_w) ? '0 : (idx2 + IW'(1));
  end

  assign mem_we = en[1] && valid_r[0] && (s1_op_r == OP_WRITE) && s1_wen_r;

  crle_point_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank0 (
    .clk(clk), .we(mem_we), .waddr(s1_waddr_r), .wdata(s1_point_r),
    .re(en[1]), .raddr(idx0[AW-1:0]), .rdata(pt0)
  );
  crle_point_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank1 (
    .clk(clk), .we(mem_we), .waddr(s1_waddr_r), .wdata(s1_point_r),
    .re(en[1]), .raddr(idx1[AW-1:0]), .rdata(pt1)
  );
  crle_point_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank2 (
    .clk(clk), .we(mem_we), .waddr(s1_waddr_r), .wdata(s1_point_r),
    .re(en[1]), .raddr(idx2[AW-1:0]), .rdata(pt2)
  );
  crle_point_bank #(.DEPTH(MAX_POINTS), .AW(AW)) u_bank3 (
    .clk(clk), .we(mem_we), .waddr(s1_waddr_r), .wdata(s1_point_r),
    .re(en[1]), .raddr(idx3[AW-1:0]), .rdata(pt3)
  );

  assign lane_en.coef = en[2];
  assign lane_en.mul1 = en[3];
  assign lane_en.add1 = en[4];
  assign lane_en.mul2 = en[5];
  assign lane_en.add2 = en[6];
  assign lane_en.mul3 = en[7];
  assign lane_en.add3 = en[8];

  crle_axis_lane u_lane_x (
    .clk(clk), .en(lane_en), .p0(pt0.x), .p1(pt1.x), .p2(pt2.x), .p3(pt3.x),
    .t_in(s2_t_r), .pos(pos_x), .slope(slope_x)
  );
  crle_axis_lane u_lane_y (
    .clk(clk), .en(lane_en), .p0(pt0.y), .p1(pt1.y), .p2(pt2.y), .p3(pt3.y),
    .t_in(s2_t_r), .pos(pos_y), .slope(slope_y)
  );
  crle_axis_lane u_lane_z (
    .clk(clk), .en(lane_en), .p0(pt0.z), .p1(pt1.z), .p2(pt2.z), .p3(pt3.z),
    .t_in(s2_t_r), .pos(pos_z), .slope(slope_z)
  );

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      pos_x_r   <= pos_x;
      pos_y_r   <= pos_y;
      pos_z_r   <= pos_z;
      slope_x_r <= slope_x;
      slope_y_r <= slope_y;
      slope_z_r <= slope_z;
    end
  end

  assign out_valid   = valid_r[NST-1];
  assign out_pos_x   = pos_x_r;
  assign out_pos_y   = pos_y_r;
  assign out_pos_z   = pos_z_r;
  assign out_slope_x = slope_x_r;
  assign out_slope_y = slope_y_r;
  assign out_slope_z = slope_z_r;

`ifndef ASSERT_OFF
  a_seg_in_loop: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r[0] |-> (s1_seg_r < s1_n_r) && (s1_n_r != 7'd0))
    else $error("segment index outside the loop");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while the pipeline can still advance");

  a_write_drops_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en[1] && valid_r[0]) |=> (valid_r[1] == $past(s1_op_r == OP_EVAL)))
    else $error("read stage carried a write item or lost an evaluation");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !valid_r[NST-2]) |=> !out_valid)
    else $error("result appeared without an item behind it");
`endif

endmodule

`default_nettype wire
